// File: hdl/sha256_hash_engine_macros.svh
// assertion macros for the hash engine checker
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH

`define SHA_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");

`define SHA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");

`endif

// File: hdl/sha_pkg.sv
package sha_pkg;

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic       take_word;
    logic       pad_step;
    logic       round_start;
    logic       round_step;
    logic       round_finish;
    logic       reload;
    logic       emit_step;
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic       block_full;
    logic       window_full;
    logic       pad_done;
    logic       rounds_done;
    logic       last_word;
    logic       pad_pending;
  } sts_t;

  localparam logic [31:0] Iv256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] Iv224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] iv_word(input logic mode, input logic [2:0] i);
    iv_word = mode ? Iv224[i] : Iv256[i];
  endfunction

endpackage

// File: hdl/sha_ctrl.sv
module sha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  input  logic            cfg_busy,
  output logic            cfg_ready,
  input  sha_pkg::sts_t   sts,
  input  logic            emit_last,
  output sha_pkg::cmd_t   cmd
);

  sha_pkg::state_t state, state_next;

  assign cfg_ready = (state == sha_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: begin
        in_stall = cfg_busy;
        if (in_valid && !cfg_busy) begin
          cmd.take_word = 1'b1;
          if (sts.last_word || sts.block_full) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        // pad a last word until the window holds a full block, then run rounds
        if (!sts.window_full && sts.pad_pending && !sts.pad_done) begin
          cmd.pad_step = 1'b1;
        end else begin
          cmd.round_start = 1'b1;
          state_next = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (sts.rounds_done) begin
          state_next = sha_pkg::ST_FINAL;
        end
      end
      sha_pkg::ST_FINAL: begin
        cmd.round_finish = 1'b1;
        if (!sts.pad_pending) begin
          state_next = sha_pkg::ST_IDLE;
        end else if (sts.pad_done) begin
          state_next = sha_pkg::ST_EMIT;
        end else begin
          state_next = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_step = 1'b1;
          if (emit_last) begin
            cmd.reload = 1'b1;
            state_next = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hdl/sha_dpath.sv
module sha_dpath (
  input  logic            clk,
  input  logic            rst,
  input  sha_pkg::cmd_t   cmd,
  output sha_pkg::sts_t   sts,
  input  logic            cfg_write,
  input  logic            cfg_mode,
  input  logic [31:0]     message_word,
  input  logic [2:0]      byte_count,
  input  logic            last_item,
  output logic [31:0]     digest_word,
  output logic [2:0]      word_index,
  output logic            digest_end
);

  logic        mode;
  logic [31:0] chain [8];
  logic [31:0] wbuf [16];
  logic [3:0]  fill;
  logic [60:0] total;
  logic [31:0] rv [8];
  logic [5:0]  rnd;
  logic        pend;
  logic        pdone;
  logic        pzero;
  logic        lhi;
  logic        wfull;
  logic [2:0]  oidx;

  logic [2:0]  cnt;
  logic [31:0] mask_word;
  logic [60:0] total_next;
  logic [63:0] bits;
  logic [31:0] t1, t2, s0, s1, wnew;
  logic [31:0] pad_word;
  logic        fill_wrap;

  always_comb begin
    cnt = last_item ? ((byte_count > 3'd4) ? 3'd4 : byte_count) : 3'd4;
    case (cnt)
      3'd0: mask_word = {sha_pkg::PadByte, 24'h0};
      3'd1: mask_word = {message_word[31:24], sha_pkg::PadByte, 16'h0};
      3'd2: mask_word = {message_word[31:16], sha_pkg::PadByte, 8'h0};
      3'd3: mask_word = {message_word[31:8], sha_pkg::PadByte};
      default: mask_word = message_word;
    endcase
    total_next = total + 61'(cnt);
    bits = {total, 3'b000};
    if (pzero) begin
      pad_word = {sha_pkg::PadByte, 24'h0};
    end else if (fill == 4'd14) begin
      pad_word = bits[63:32];
    end else if (fill == 4'd15) begin
      pad_word = lhi ? bits[31:0] : 32'h0;
    end else begin
      pad_word = 32'h0;
    end
    fill_wrap = (fill == 4'd15);
    s0 = sha_pkg::ror32(wbuf[1], 7) ^ sha_pkg::ror32(wbuf[1], 18) ^ (wbuf[1] >> 3);
    s1 = sha_pkg::ror32(wbuf[14], 17) ^ sha_pkg::ror32(wbuf[14], 19) ^ (wbuf[14] >> 10);
    wnew = s1 + wbuf[9] + s0 + wbuf[0];
    t1 = rv[7] + (sha_pkg::ror32(rv[4], 6) ^ sha_pkg::ror32(rv[4], 11)
         ^ sha_pkg::ror32(rv[4], 25)) + ((rv[4] & rv[5]) ^ (~rv[4] & rv[6]))
         + sha_pkg::RoundK[rnd] + wbuf[0];
    t2 = (sha_pkg::ror32(rv[0], 2) ^ sha_pkg::ror32(rv[0], 13) ^ sha_pkg::ror32(rv[0], 22))
         + ((rv[0] & rv[1]) ^ (rv[0] & rv[2]) ^ (rv[1] & rv[2]));
  end

  assign sts.block_full = fill_wrap && !(last_item && cnt != 3'd4);
  assign sts.window_full = wfull;
  assign sts.last_word = last_item;
  assign sts.pad_pending = pend;
  assign sts.pad_done = pdone;
  assign sts.rounds_done = (rnd == 6'd63);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      fill <= '0;
      total <= '0;
      pend <= 1'b0;
      pdone <= 1'b0;
      pzero <= 1'b0;
      lhi <= 1'b0;
      wfull <= 1'b0;
      rnd <= '0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::iv_word(1'b0, 3'(i));
    end else if (cfg_write) begin
      mode <= cfg_mode;
      fill <= '0;
      total <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::iv_word(cfg_mode, 3'(i));
    end else begin
      if (cmd.take_word) begin
        total <= total_next;
        fill <= fill + 4'd1;
        if (fill_wrap) wfull <= 1'b1;
        if (last_item) begin
          pend <= 1'b1;
          pdone <= 1'b0;
          lhi <= 1'b0;
          // full last word: marker byte goes into the next word
          pzero <= (cnt == 3'd4);
        end
      end
      if (cmd.pad_step) begin
        fill <= fill + 4'd1;
        pzero <= 1'b0;
        if (fill_wrap) wfull <= 1'b1;
        if (!pzero && fill == 4'd14) lhi <= 1'b1;
        if (!pzero && fill == 4'd15 && lhi) pdone <= 1'b1;
      end
      if (cmd.round_start) begin
        rnd <= '0;
        wfull <= 1'b0;
      end
      if (cmd.round_step) rnd <= rnd + 6'd1;
      if (cmd.round_finish) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + rv[i];
      end
      if (cmd.reload) begin
        pend <= 1'b0;
        pdone <= 1'b0;
        fill <= '0;
        total <= '0;
        oidx <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::iv_word(mode, 3'(i));
      end else if (cmd.emit_step) begin
        oidx <= oidx + 3'd1;
      end
    end
  end

  // message schedule window and working variables
  always_ff @(posedge clk) begin
    if (cmd.take_word) begin
      for (int i = 0; i < 15; i++) wbuf[i] <= wbuf[i + 1];
      wbuf[15] <= last_item ? mask_word : message_word;
    end else if (cmd.pad_step) begin
      for (int i = 0; i < 15; i++) wbuf[i] <= wbuf[i + 1];
      wbuf[15] <= pad_word;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) wbuf[i] <= wbuf[i + 1];
      wbuf[15] <= wnew;
    end
    if (cmd.round_start) begin
      for (int i = 0; i < 8; i++) rv[i] <= chain[i];
    end else if (cmd.round_step) begin
      rv[7] <= rv[6]; rv[6] <= rv[5]; rv[5] <= rv[4];
      rv[4] <= rv[3] + t1;
      rv[3] <= rv[2]; rv[2] <= rv[1]; rv[1] <= rv[0];
      rv[0] <= t1 + t2;
    end
  end

  assign digest_word = chain[oidx];
  assign word_index = oidx;
  assign digest_end = mode ? (oidx == 3'd6) : (oidx == 3'd7);

endmodule

// File: hdl/sha256_hash_engine.sv
// SHA-256 / SHA-224 engine. Message words enter on in_valid/in_stall, first byte in
// bits 31:24; every sixteenth word (a full 64-byte block) holds input while it is
// compressed, one round per cycle in a single round unit. The last word triggers
// padding and a compression for each remaining block, two blocks when the marker
// byte leaves no room for the length, then 8 (SHA-256) or 7 (SHA-224) digest words,
// one per cycle on out_valid/out_stall while out_stall is low.
// digest_mode is written through cfg_valid/cfg_ready while idle and restarts the message.
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] message_word,
  input  logic [2:0]  byte_count,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        digest_mode
);

  sha_pkg::cmd_t cmd;
  sha_pkg::sts_t sts;
  logic          cfg_write;

  assign cfg_write = cfg_valid && cfg_ready;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_stall, .out_valid,
    .cfg_busy(cfg_valid), .cfg_ready, .sts, .emit_last(digest_end), .cmd
  );

  sha_dpath u_dpath (
    .clk, .rst, .cmd, .sts,
    .cfg_write(cfg_write), .cfg_mode(digest_mode),
    .message_word, .byte_count, .last_item,
    .digest_word, .word_index, .digest_end
  );

endmodule

// File: hdl/sha_checker.sv
`include "sha256_hash_engine_macros.svh"

module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  word_index,
  input logic        digest_end
);

  `SHA_ASSERT_IMP(no_in_during_out, out_valid, in_stall)
  `SHA_ASSERT_NEXT(index_steps, out_valid && !out_stall && !digest_end, out_valid && word_index == $past(word_index) + 3'd1)
  `SHA_ASSERT_NEXT(end_closes, out_valid && !out_stall && digest_end, !out_valid)
  `SHA_ASSERT_IMP(end_position, out_valid && digest_end, word_index == 3'd6 || word_index == 3'd7)

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .word_index, .digest_end
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        last;
    logic [31:0] known_w0;
    logic        has_known;
  } row_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] message_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_item = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_end;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        digest_mode = 0;

  sha256_hash_engine u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .message_word(message_word), .byte_count(byte_count), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .digest_end(digest_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .digest_mode(digest_mode)
  );

  always #1 clk = ~clk;

  // hash model state
  logic        mdl_mode;
  logic [31:0] mdl_chain [8];
  logic [31:0] mdl_block [16];
  int          mdl_fill;
  logic [60:0] mdl_bytes;
  digest_t     digest_q[$];
  logic [31:0] first_words[$];

  int n_words_in, n_digest_words, n_msgs, n_mode_writes, n_mismatch, idle_cycles;
  bit quiet, held;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void load_chain();
    for (int i = 0; i < 8; i++)
      mdl_chain[i] = mdl_mode ? sha_pkg::Iv224[i] : sha_pkg::Iv256[i];
    mdl_fill = 0;
    mdl_bytes = '0;
  endfunction

  function automatic void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = mdl_block[t];
    for (int t = 16; t < 64; t++)
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    v = mdl_chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) mdl_chain[i] += v[i];
  endfunction

  function automatic void add_byte(logic [7:0] b);
    if (mdl_fill % 4 == 0) mdl_block[mdl_fill / 4] = '0;
    mdl_block[mdl_fill / 4] |= 32'(b) << (24 - 8 * (mdl_fill % 4));
    mdl_fill = (mdl_fill + 1) % 64;
    if (mdl_fill == 0) compress();
  endfunction

  function automatic void absorb_word(logic [31:0] w, logic [2:0] c, logic l);
    int nb, nd;
    logic [63:0] bits;
    digest_t d;
    nb = l ? ((c > 4) ? 4 : int'(c)) : 4;
    for (int i = 0; i < nb; i++) add_byte(w[31 - 8 * i -: 8]);
    mdl_bytes += 61'(nb);
    if (!l) return;
    add_byte(sha_pkg::PadByte);
    while (mdl_fill != 56) add_byte(8'h00);
    bits = {mdl_bytes, 3'b000};
    for (int i = 0; i < 8; i++) add_byte(bits[63 - 8 * i -: 8]);
    nd = mdl_mode ? 7 : 8;
    for (int i = 0; i < nd; i++) begin
      d.word = mdl_chain[i];
      d.idx = 3'(i);
      d.fin = (i == nd - 1);
      digest_q.push_back(d);
    end
    first_words.push_back(mdl_chain[0]);
    n_msgs++;
    load_chain();
  endfunction

  // transaction monitor, checker and watchdog
  always @(posedge clk) begin
    digest_t e;
    if (!rst) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        absorb_word(message_word, byte_count, last_item);
        n_words_in++;
        idle_cycles = 0;
      end
      if (cfg_valid && cfg_ready) begin
        mdl_mode = digest_mode;
        load_chain();
        n_mode_writes++;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        n_digest_words++;
        if (digest_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected digest word %h", digest_word);
        end else begin
          e = digest_q.pop_front();
          if (e.word !== digest_word || e.idx !== word_index || e.fin !== digest_end) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d", e.word, e.idx,
                       e.fin, digest_word, word_index, digest_end);
          end
        end
      end
      if (idle_cycles >= 5000) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("sha256_hash_engine verification failed");
        $finish;
      end
    end
  end

  // receiver side, with one long hold-off
  always @(posedge clk) begin
    if (!held && n_digest_words >= 60) begin
      held = 1;
      out_stall <= 1;
      repeat (400) @(posedge clk);
    end else begin
      out_stall <= (!quiet && $urandom_range(0, 99) < 12);
    end
  end

  task automatic send_word(logic [31:0] w, logic [2:0] c, logic l);
    in_valid <= 1;
    message_word <= w;
    byte_count <= c;
    last_item <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid <= 1;
    digest_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_messages(int n_items);
    int sent, nw;
    sent = 0;
    while (sent < n_items) begin
      nw = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 18);
      for (int i = 0; i < nw; i++) send_word($urandom(), 3'($urandom_range(0, 7)), 0);
      send_word($urandom(), 3'($urandom_range(0, 7)), 1);
      sent += nw + 1;
    end
  endtask

  row_t table_rows[] = '{
    '{32'h00000000, 3'd0, 1'b1, 32'he3b0c442, 1'b1},
    '{32'h61626300, 3'd3, 1'b1, 32'hba7816bf, 1'b1},
    '{32'hffffffff, 3'd4, 1'b1, 32'h0, 1'b0},
    '{32'h00000000, 3'd7, 1'b1, 32'h0, 1'b0},
    '{32'haabbccdd, 3'd1, 1'b1, 32'h0, 1'b0},
    '{32'h12345678, 3'd2, 1'b1, 32'h0, 1'b0},
    '{32'hffffffff, 3'd7, 1'b0, 32'h0, 1'b0},
    '{32'h00000000, 3'd0, 1'b0, 32'h0, 1'b0},
    '{32'h80000001, 3'd5, 1'b0, 32'h0, 1'b0},
    '{32'h7ffffffe, 3'd2, 1'b0, 32'h0, 1'b0},
    '{32'hdeadbeef, 3'd1, 1'b0, 32'h0, 1'b0},
    '{32'h01234567, 3'd6, 1'b0, 32'h0, 1'b0},
    '{32'h89abcdef, 3'd3, 1'b0, 32'h0, 1'b0},
    '{32'h55555555, 3'd4, 1'b0, 32'h0, 1'b0},
    '{32'haaaaaaaa, 3'd0, 1'b0, 32'h0, 1'b0},
    '{32'h0f0f0f0f, 3'd7, 1'b0, 32'h0, 1'b0},
    '{32'hf0f0f0f0, 3'd1, 1'b0, 32'h0, 1'b0},
    '{32'h13579bdf, 3'd2, 1'b0, 32'h0, 1'b0},
    '{32'h2468ace0, 3'd5, 1'b0, 32'h0, 1'b0},
    '{32'hcafef00d, 3'd3, 1'b1, 32'h0, 1'b0}
  };

  initial begin
    int msg_no;
    int known_at[$];
    logic [31:0] known_val[$];
    mdl_mode = 0;
    load_chain();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    msg_no = 0;
    foreach (table_rows[i]) begin
      if (table_rows[i].has_known) begin
        known_at.push_back(msg_no);
        known_val.push_back(table_rows[i].known_w0);
      end
      if (table_rows[i].last) msg_no++;
      send_word(table_rows[i].word, table_rows[i].cnt, table_rows[i].last);
    end
    drain();
    foreach (known_at[k])
      if (first_words[known_at[k]] !== known_val[k]) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("known digest mismatch: exp %h got %h", known_val[k],
                   first_words[known_at[k]]);
      end

    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] ? 1'b0 : 1'b1);
      quiet = (ph == 1);
      random_messages(80);
      // stray words left behind, dropped by the next mode write
      if (ph == 0 || ph == 2)
        for (int i = 0; i < 5; i++) send_word($urandom(), 3'($urandom_range(0, 7)), 0);
      drain();
    end

    $display("run covered %0d message words, %0d digests, %0d digest words",
             n_words_in, n_msgs, n_digest_words);
    $display("both digest modes over %0d mode writes, %0d mismatches",
             n_mode_writes, n_mismatch);
    if (n_mismatch == 0 && digest_q.size() == 0)
      $display("sha256_hash_engine verification clean");
    else
      $display("sha256_hash_engine verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/sha_pkg.sv
hdl/sha_ctrl.sv
hdl/sha_dpath.sv
hdl/sha256_hash_engine.sv
hdl/sha_checker.sv
tb/tb.sv
